/* src/mtg_pkg.sv */
// Shared types, constants and the tempering function of the MT19937 generator.
`timescale 1ns / 1ps

package mtg_pkg;

    // Word and state-memory geometry.
    localparam int WORD_W   = 32;
    localparam int MT_WORDS = 624;
    localparam int MT_SHIFT = 397;
    localparam int MT_TAIL  = MT_WORDS - MT_SHIFT;
    localparam int ADDR_W   = $clog2(MT_WORDS);

    // Default depth of the request queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [ADDR_W-1:0] addr_t;

    // Algorithm constants.
    localparam word_t SEED_RESET   = 32'd5489;
    localparam word_t MT_INIT_MULT = 32'd1812433253;
    localparam word_t MT_MATRIX    = 32'd2567483615;
    localparam word_t MT_TEMPER_B  = 32'd2636928640;
    localparam word_t MT_TEMPER_C  = 32'd4022730752;
    localparam addr_t LAST_ADDR    = addr_t'(MT_WORDS - 1);
    localparam addr_t SHIFT_ADDR   = addr_t'(MT_SHIFT);
    localparam addr_t TAIL_ADDR    = addr_t'(MT_TAIL);

    // One queued request as seen by the back end.
    typedef struct packed {
        logic valid;
        logic need_seed;
    } cmd_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        B_IDLE,
        B_SEED,
        B_READ,
        B_TWIST
    } back_state_t;

    // Output tempering of one state word.
    function automatic word_t temper(input word_t w);
        word_t y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & MT_TEMPER_B);
        y = y ^ ((y << 15) & MT_TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

/* src/mtg_ram.sv */
// Generic single-write, dual-read RAM with registered read data.
`timescale 1ns / 1ps

module mtg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and two registered read ports.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

/* src/mtg_front.sv */
// Front end: seed register, request classification and the request queue.
`timescale 1ns / 1ps

module mtg_front #(
    parameter int QUEUE_DEPTH = mtg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  mtg_pkg::word_t seed_value,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          reseed,
    output mtg_pkg::cmd_t cmd,
    input  logic          pop,
    output mtg_pkg::word_t seed_word
);
    import mtg_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    word_t              seed_reg;
    logic               seeded_reg;
    logic [QUEUE_DEPTH-1:0] entry_reg;
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               push;

    // The seed register takes a beat in any cycle.
    assign cfg_ready = 1'b1;
    assign seed_word = seed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= SEED_RESET;
        end
        else if (cfg_valid)
        begin
            seed_reg <= seed_value;
        end
    end

    // A request needs a seeding walk if it asks for one or nothing was seeded yet.
    assign in_ready = (count_reg != CNT_FULL);
    assign push     = in_valid && in_ready;

    assign cmd.valid     = (count_reg != '0);
    assign cmd.need_seed = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= reseed || !seeded_reg;
        end
    end

    // Queue pointers, fill count and the seeded flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeded_reg <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                seeded_reg <= 1'b1;
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* src/mtg_back.sv */
// Back end: seeding walk, per-draw twist of one state word, tempering and output register.
`timescale 1ns / 1ps

module mtg_back (
    input  logic           clk,
    input  logic           rst_n,
    input  mtg_pkg::cmd_t  cmd,
    output logic           pop,
    input  mtg_pkg::word_t seed_word,
    output logic           out_valid,
    input  logic           out_ready,
    output mtg_pkg::word_t random_word
);
    import mtg_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;
    addr_t       seed_idx_reg;
    addr_t       pos_reg;
    word_t       prev_reg;
    logic        upper_reg;
    logic        out_valid_reg;
    word_t       word_reg;

    addr_t       nxt_addr;
    addr_t       far_addr;
    word_t       seed_mix;
    word_t       seed_next;
    word_t       y;
    word_t       twisted;
    logic        we;
    addr_t       waddr;
    word_t       wdata;
    word_t       rdata_a;
    word_t       rdata_b;

    // Neighbor and far addresses of the word being drawn.
    assign nxt_addr = (pos_reg == LAST_ADDR) ? '0 : pos_reg + 1'b1;
    assign far_addr = (pos_reg < TAIL_ADDR) ? pos_reg + SHIFT_ADDR : pos_reg - TAIL_ADDR;

    // Seeding recurrence on the previous word.
    assign seed_mix  = prev_reg ^ (prev_reg >> 30);
    assign seed_next = (seed_idx_reg == '0) ? prev_reg
                     : (MT_INIT_MULT * seed_mix) + {{(WORD_W-ADDR_W){1'b0}}, seed_idx_reg};

    // Twist of the word at the draw position. Words before it are already
    // regenerated, words from it on are not, as in an in-place full twist.
    assign y       = {upper_reg, rdata_a[WORD_W-2:0]};
    assign twisted = rdata_b ^ (y >> 1) ^ (y[0] ? MT_MATRIX : '0);

    mtg_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MT_WORDS)
    ) u_state_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (nxt_addr),
        .raddr_b (far_addr),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // Next state, queue pop and memory write.
    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        we         = 1'b0;
        waddr      = pos_reg;
        wdata      = twisted;
        case (state_reg)
            B_IDLE:
            begin
                if (cmd.valid && (!out_valid_reg || out_ready))
                begin
                    pop        = 1'b1;
                    state_next = cmd.need_seed ? B_SEED : B_READ;
                end
            end
            B_SEED:
            begin
                we    = 1'b1;
                waddr = seed_idx_reg;
                wdata = seed_next;
                if (seed_idx_reg == LAST_ADDR)
                begin
                    state_next = B_READ;
                end
            end
            B_READ:
            begin
                state_next = B_TWIST;
            end
            B_TWIST:
            begin
                we         = 1'b1;
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            pos_reg       <= '0;
            seed_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    seed_idx_reg <= '0;
                end
                B_SEED:
                begin
                    seed_idx_reg <= seed_idx_reg + 1'b1;
                    if (seed_idx_reg == LAST_ADDR)
                    begin
                        pos_reg <= '0;
                    end
                end
                B_TWIST:
                begin
                    pos_reg       <= nxt_addr;
                    out_valid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Datapath registers. The upper bit of the word at the draw position is
    // only reloaded from the seed when a seeding walk starts.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            prev_reg <= seed_word;
            if (cmd.need_seed)
            begin
                upper_reg <= seed_word[WORD_W-1];
            end
        end
        if (state_reg == B_SEED)
        begin
            prev_reg <= seed_next;
        end
        if (state_reg == B_TWIST)
        begin
            upper_reg <= rdata_a[WORD_W-1];
            word_reg  <= temper(twisted);
        end
    end

    assign out_valid   = out_valid_reg;
    assign random_word = word_reg;

endmodule

/* src/mersenne_twister_generator_unit.sv */
// A draw leaves the request queue, passes the read and twist states and its tempered word
// is registered on the output; a seeding request first walks all 624 state words, one word
// per cycle through the seeding multiplier. A new request is only taken in idle, after the
// read-then-twist sequence on the dual-read state memory. Reset is asynchronous, active low:
// it clears the queue, the sequencer and the draw position and restores the seed to 5489.
// The state memory is not cleared; the first request after reset always seeds it.
`timescale 1ns / 1ps

module mersenne_twister_generator_unit #(
    parameter int QUEUE_DEPTH = mtg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  mtg_pkg::word_t seed_value,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           reseed,
    output logic           out_valid,
    input  logic           out_ready,
    output mtg_pkg::word_t random_word
);
    import mtg_pkg::*;

    cmd_t  cmd;
    logic  pop;
    word_t seed_word;

    // Request acceptance and queue.
    mtg_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .seed_value (seed_value),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .reseed     (reseed),
        .cmd        (cmd),
        .pop        (pop),
        .seed_word  (seed_word)
    );

    // Generator proper.
    mtg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .pop         (pop),
        .seed_word   (seed_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .random_word (random_word)
    );

    // The back end only takes a request that is really queued.
    a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cmd.valid)
        else $error("request popped from an empty queue");

    // A request is only started when the output slot will be free for its word.
    a_pop_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (!out_valid || out_ready))
        else $error("request started while the output slot stays occupied");

    // An accepted beat is visible to the back end in the next cycle.
    a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> cmd.valid)
        else $error("accepted request missing from the queue");

    // An empty queue always takes a beat.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.valid |-> in_ready)
        else $error("empty queue refuses a request");

endmodule
